// ----- src/klvhp_pkg.sv -----
// ----------------------------------------------------------------------------
// klvhp_pkg
// Shared types and constants for the KLV header parser: result word layout,
// status codes and BER length-field constants.
// ----------------------------------------------------------------------------
package klvhp_pkg;

   // Key size in bytes and in bits
   localparam int KeyBytes = 16;
   localparam int KeyBits  = KeyBytes * 8;

   // BER length byte decoding
   localparam logic [7:0] BER_LONG_FORM = 8'h80;
   localparam logic [6:0] COUNT_MASK    = 7'h7f;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_COUNT = 2'd1,
      ST_EOD   = 2'd2
   } status_type;

   // One result word
   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [3:0]  length_field_bytes;
      logic [63:0] value_length;
      status_type  status;
   } result_type;

endpackage

// ----- src/klvhp_parse.sv -----
// ----------------------------------------------------------------------------
// klvhp_parse
// Header parse engine: holds the key shift register, the phase and the BER
// length accumulator, and forms a result word when a header ends.
// ----------------------------------------------------------------------------
module klvhp_parse import klvhp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_data,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [1:0] {
      PH_KEY       = 2'd0,
      PH_FIRST_LEN = 2'd1,
      PH_MORE_LEN  = 2'd2,
      PH_SPARE     = 2'd3
   } phase_type;

   phase_type           phase_ff,     phase_in;
   logic [3:0]          key_count_ff, key_count_in;
   logic [KeyBits-1:0]  key_ff,       key_in;
   logic [63:0]         acc_ff,       acc_in;
   logic [3:0]          left_ff,      left_in;
   logic [3:0]          size_ff,      size_in;

   logic [6:0]          count;
   logic                emit;

   assign count = data_byte[6:0] & COUNT_MASK;

   // Decode one byte against the current phase
   always_comb begin
      phase_in     = phase_ff;
      key_count_in = key_count_ff;
      key_in       = key_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      size_in      = size_ff;
      emit         = 1'b0;
      res          = '{key_high: key_ff[KeyBits-1 -: 64], key_low: key_ff[63:0],
                       length_field_bytes: 4'd0, value_length: 64'd0,
                       status: ST_OK};

      priority if (end_of_data) begin
         emit = 1'b1;
         res  = '{key_high: 64'd0, key_low: 64'd0, length_field_bytes: 4'd0,
                  value_length: 64'd0, status: ST_EOD};
      end else begin
         unique case (phase_ff)
            PH_FIRST_LEN: begin
               priority if ((data_byte & BER_LONG_FORM) == 8'd0) begin
                  emit                   = 1'b1;
                  res.length_field_bytes = 4'd1;
                  res.value_length       = {56'd0, data_byte};
               end else if (count == 7'd0) begin
                  emit                   = 1'b1;
                  res.length_field_bytes = 4'd1;
               end else if (count > 7'(MAX_LENGTH_BYTES)) begin
                  emit       = 1'b1;
                  res.status = ST_COUNT;
               end else begin
                  acc_in   = 64'd0;
                  left_in  = count[3:0];
                  size_in  = count[3:0] + 4'd1;
                  phase_in = PH_MORE_LEN;
               end
            end
            PH_MORE_LEN: begin
               acc_in = {acc_ff[55:0], data_byte};
               if (left_ff > 4'd0) begin
                  left_in = left_ff - 4'd1;
               end
               if (left_ff <= 4'd1) begin
                  emit                   = 1'b1;
                  res.length_field_bytes = size_ff;
                  res.value_length       = acc_in;
               end
            end
            default: begin
               // Key phase, spare code included
               phase_in     = PH_KEY;
               key_in       = {key_ff[KeyBits-9:0], data_byte};
               key_count_in = key_count_ff + 4'd1;
               if (key_count_ff == 4'(KeyBytes - 1)) begin
                  key_count_in = 4'd0;
                  phase_in     = PH_FIRST_LEN;
               end
            end
         endcase
      end
   end

   assign res_valid = step & emit;

   // Hold parse state; restart at a new key after every result
   always_ff @(posedge clock) begin
      if (reset || res_valid) begin
         phase_ff     <= PH_KEY;
         key_count_ff <= 4'd0;
         key_ff       <= '0;
         acc_ff       <= 64'd0;
         left_ff      <= 4'd0;
         size_ff      <= 4'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         key_count_ff <= key_count_in;
         key_ff       <= key_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         size_ff      <= size_in;
      end
   end

endmodule

// ----- src/klvhp_out_reg.sv -----
// ----------------------------------------------------------------------------
// klvhp_out_reg
// Result register: holds one finished result word until the consumer takes
// it, and loads a new one in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module klvhp_out_reg import klvhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_word,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_word,
   output logic       busy
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   // Stay full while stalled, refill on a new result
   assign valid_in = load | (valid_ff & out_stall);
   assign busy     = valid_ff & out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- src/klv_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// klv_header_parser_core
// KLV header parser: shifts in a 16-byte key and a BER length, one byte a
// word, and returns key, length field size, value length and status.
// ----------------------------------------------------------------------------
// A result appears on rsp_ in the cycle after the byte that ends it.
// Throughput: one byte per cycle; the input stalls only while a result word
// is held in the output register under rsp_stall.
// Reset (synchronous, active high) returns the parser to the key phase with
// an empty key and length, and empties the output register.
module klv_header_parser_core import klvhp_pkg::*; #(
   parameter int MAX_LENGTH_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_key_high,
   output logic [63:0] rsp_key_low,
   output logic [3:0]  rsp_length_field_bytes,
   output logic [63:0] rsp_value_length,
   output logic [1:0]  rsp_status
);

   logic       step;
   logic       res_valid;
   result_type res;
   result_type out_word;
   logic       busy;

   // Accept a byte whenever the result register can take a word
   assign req_stall = busy;
   assign step      = req_valid & ~req_stall;

   klvhp_parse #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (req_data_byte),
      .end_of_data (req_end_of_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   klvhp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_word (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_word  (out_word),
      .busy      (busy)
   );

   assign rsp_key_high           = out_word.key_high;
   assign rsp_key_low            = out_word.key_low;
   assign rsp_length_field_bytes = out_word.length_field_bytes;
   assign rsp_value_length       = out_word.value_length;
   assign rsp_status             = out_word.status;

   // End of data always yields a result in the next cycle
   a_eod_result: assert property (@(posedge clock) disable iff (reset)
      step && req_end_of_data |=> rsp_valid && rsp_status == ST_EOD)
      else $error("end of data gave no status word");

   // Field size is zero exactly on error
   a_size_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_length_field_bytes == 4'd0) == (rsp_status != ST_OK)))
      else $error("length field size disagrees with status");

   // Error words carry no length
   a_error_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value_length == 64'd0)
      else $error("error word carries a length");

   // No new result may be loaded while a word is held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !res_valid)
      else $error("held result overwritten");

endmodule

// ----- test/klv_header_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klv_header_parser_core_tb
// Self-checking bench for the KLV header parser. Byte streams of directed and
// random headers go in word by word with random gaps, results come out under
// random stall, and each result is checked against a software parser kept in
// step with every accepted byte.
// ----------------------------------------------------------------------------
module klv_header_parser_core_tb;
   import klvhp_pkg::*;

   localparam int MaxLengthBytes = 8;
   localparam int RandomWords    = 1000;
   localparam int WatchdogLimit  = 400;

   typedef enum logic [1:0] {
      PH_KEY       = 2'd0,
      PH_FIRST_LEN = 2'd1,
      PH_MORE_LEN  = 2'd2
   } phase_type;

   typedef logic [7:0] byte_q_type [$];

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_key_high;
   logic [63:0] rsp_key_low;
   logic [3:0]  rsp_length_field_bytes;
   logic [63:0] rsp_value_length;
   logic [1:0]  rsp_status;

   // Parser state as the block should hold it
   phase_type   parse_phase;
   logic [4:0]  key_count;
   logic [63:0] key_high_store;
   logic [63:0] key_low_store;
   logic [63:0] length_acc;
   logic [3:0]  length_left;
   logic [3:0]  length_size;

   result_type  pending_headers [$];
   int          mismatch_count = 0;
   int          words_sent     = 0;
   int          send_idle_max  = 0;
   int          rx_idle_max    = 0;

   klv_header_parser_core #(
      .MAX_LENGTH_BYTES(MaxLengthBytes)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_end_of_data        (req_end_of_data),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_key_high           (rsp_key_high),
      .rsp_key_low            (rsp_key_low),
      .rsp_length_field_bytes (rsp_length_field_bytes),
      .rsp_value_length       (rsp_value_length),
      .rsp_status             (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Return the parser to an empty key phase
   function automatic void clear_parser();
      parse_phase    = PH_KEY;
      key_count      = '0;
      key_high_store = '0;
      key_low_store  = '0;
      length_acc     = '0;
      length_left    = '0;
      length_size    = '0;
   endfunction

   // Build one result word and restart at a new key
   function automatic result_type close_header(input logic with_key,
                                               input logic [3:0] field_bytes,
                                               input logic [63:0] length,
                                               input status_type st);
      result_type r;
      r.key_high           = with_key ? key_high_store : '0;
      r.key_low            = with_key ? key_low_store : '0;
      r.length_field_bytes = field_bytes;
      r.value_length       = length;
      r.status             = st;
      clear_parser();
      return r;
   endfunction

   // Advance the parser by one accepted word; return 1 when a header closes
   function automatic bit parse_byte(input logic [7:0] data, input logic eod,
                                     output result_type r);
      logic [6:0] count;
      r = '0;
      if (eod) begin
         r = close_header(1'b0, 4'd0, 64'd0, ST_EOD);
         return 1'b1;
      end
      case (parse_phase)
         PH_FIRST_LEN: begin
            if (data < BER_LONG_FORM) begin
               r = close_header(1'b1, 4'd1, {56'd0, data}, ST_OK);
               return 1'b1;
            end
            count = data[6:0] & COUNT_MASK;
            if (count == 0) begin
               r = close_header(1'b1, 4'd1, 64'd0, ST_OK);
               return 1'b1;
            end
            if (count > MaxLengthBytes) begin
               r = close_header(1'b1, 4'd0, 64'd0, ST_COUNT);
               return 1'b1;
            end
            length_acc  = '0;
            length_left = count[3:0];
            length_size = count[3:0] + 4'd1;
            parse_phase = PH_MORE_LEN;
            return 1'b0;
         end
         PH_MORE_LEN: begin
            length_acc = {length_acc[55:0], data};
            if (length_left > 0)
               length_left--;
            if (length_left == 0) begin
               r = close_header(1'b1, length_size, length_acc, ST_OK);
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            // Shift the key through both halves, first byte ends on top
            parse_phase    = PH_KEY;
            key_high_store = {key_high_store[55:0], key_low_store[63:56]};
            key_low_store  = {key_low_store[55:0], data};
            key_count      = key_count + 5'd1;
            if (key_count >= KeyBytes) begin
               key_count   = '0;
               parse_phase = PH_FIRST_LEN;
            end
            return 1'b0;
         end
      endcase
   endfunction

   // Key bytes, first length byte, then the big-endian tail where it applies
   function automatic byte_q_type header_bytes(input logic [127:0] key,
                                               input logic [7:0] first,
                                               input logic [63:0] tail);
      byte_q_type bytes;
      int count;
      for (int i = KeyBytes - 1; i >= 0; i--)
         bytes.push_back(key[i*8 +: 8]);
      bytes.push_back(first);
      count = int'(first[6:0]);
      if (first >= BER_LONG_FORM && count <= MaxLengthBytes)
         for (int i = count - 1; i >= 0; i--)
            bytes.push_back(tail[i*8 +: 8]);
      return bytes;
   endfunction

   function automatic int idle_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 11;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Send one word after a random gap and predict what it causes
   task automatic send_word(input logic [7:0] data, input logic eod);
      int gap;
      result_type done;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_end_of_data <= eod;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (parse_byte(data, eod, done))
         pending_headers.push_back(done);
   endtask

   // Send the first cut bytes; a cut short of the whole header ends in an end mark
   task automatic send_stream(input byte_q_type bytes, input int cut);
      for (int i = 0; i < bytes.size() && i < cut; i++)
         send_word(bytes[i], 1'b0);
      if (cut < bytes.size())
         send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Hold the sender until every expected result has come
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_headers.size() != 0);
   endtask

   task automatic test_end_at_start();
      send_word(8'hA5, 1'b1);
      send_word(8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_short_form();
      send_idle_max = 11;
      rx_idle_max   = 11;
      send_stream(header_bytes('0, 8'h00, '0), 99);
      send_stream(header_bytes('1, 8'h7F, '0), 99);
      send_stream(header_bytes(128'h000102030405060708090A0B0C0D0E0F, 8'h01, '0), 99);
      wait_for_results();
   endtask

   task automatic test_long_form();
      send_idle_max = 0;
      rx_idle_max   = 0;
      send_stream(header_bytes({4{$urandom}}, BER_LONG_FORM, '0), 99);
      send_stream(header_bytes({4{$urandom}}, 8'h81, 64'hFF), 99);
      send_stream(header_bytes('1, 8'h88, '1), 99);
      send_stream(header_bytes('0, 8'h88, 64'h0102030405060708), 99);
      send_stream(header_bytes({4{$urandom}}, 8'h84, {$urandom, $urandom}), 99);
      wait_for_results();
   endtask

   task automatic test_bad_count();
      send_idle_max = 3;
      rx_idle_max   = 11;
      send_stream(header_bytes({4{$urandom}}, 8'h89, '0), 99);
      send_stream(header_bytes('1, 8'hFF, '0), 99);
      wait_for_results();
   endtask

   task automatic test_end_mid_header();
      byte_q_type hdr;
      send_idle_max = 11;
      rx_idle_max   = 0;
      hdr = header_bytes({4{$urandom}}, 8'h83, {$urandom, $urandom});
      // Drop out during the key, at the first length byte, inside the tail and before the first byte
      send_stream(hdr, 7);
      send_stream(hdr, KeyBytes);
      send_stream(hdr, KeyBytes + 2);
      send_stream(hdr, 0);
      wait_for_results();
   endtask

   task automatic test_random_stream();
      byte_q_type hdr;
      logic [127:0] key;
      logic [63:0] tail;
      logic [7:0] first;
      int kind;
      int cut;
      int headers;
      int stop_at;
      headers = 0;
      stop_at = words_sent + RandomWords;
      while (words_sent < stop_at) begin
         if (headers % 8 == 0) begin
            send_idle_max = idle_limit();
            rx_idle_max   = idle_limit();
         end
         key  = {$urandom, $urandom, $urandom, $urandom};
         tail = {$urandom, $urandom};
         if ($urandom_range(0, 9) == 0)
            tail = $urandom_range(0, 1) ? '1 : '0;
         kind = $urandom_range(0, 99);
         if (kind < 35)
            first = 8'($urandom_range(0, 127));
         else if (kind < 80)
            first = BER_LONG_FORM | 8'($urandom_range(1, MaxLengthBytes));
         else if (kind < 85)
            first = BER_LONG_FORM;
         else
            first = BER_LONG_FORM | 8'($urandom_range(MaxLengthBytes + 1, 127));
         hdr = header_bytes(key, first, tail);
         // Cut about one header in ten short with an end mark
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hdr.size() - 1)
                                           : hdr.size();
         send_stream(hdr, cut);
         headers++;
         if (headers % 25 == 0)
            wait_for_results();
      end
      wait_for_results();
   endtask

   // Take result words under random stall and compare with the oldest prediction
   initial begin : result_checker
      int hold_left;
      result_type want;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_headers.size() == 0) begin
               report_mismatch("unexpected result, status", 64'(rsp_status), '0);
            end else begin
               want = pending_headers.pop_front();
               if (rsp_key_high !== want.key_high)
                  report_mismatch("key_high", rsp_key_high, want.key_high);
               if (rsp_key_low !== want.key_low)
                  report_mismatch("key_low", rsp_key_low, want.key_low);
               if (rsp_length_field_bytes !== want.length_field_bytes)
                  report_mismatch("length_field_bytes", 64'(rsp_length_field_bytes),
                                  64'(want.length_field_bytes));
               if (rsp_value_length !== want.value_length)
                  report_mismatch("value_length", rsp_value_length, want.value_length);
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
            end
            hold_left = $urandom_range(0, rx_idle_max);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // End the run when neither channel moves a word for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit)
            break;
      end
      $display("klv_header_parser_core test failed");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= '0;
      req_end_of_data <= 1'b0;
      clear_parser();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_end_at_start();
      test_short_form();
      test_long_form();
      test_bad_count();
      test_end_mid_header();
      test_random_stream();

      // Let the last result word clear the output register
      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("klv_header_parser_core test passed");
      else
         $display("klv_header_parser_core test failed");
      $finish;
   end

endmodule
